[sv/connection_slot_table_assert.svh]
// ----------------------------------------------------------------------------
// Connection slot table assertion macros
// Shared assertion forms for the connection slot table design.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_SLOT_TABLE_ASSERT_SVH
`define CONNECTION_SLOT_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("connection_slot_table: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("connection_slot_table: assertion failed");

`endif

[sv/cst_pkg.sv]
// ----------------------------------------------------------------------------
// Connection slot table package
// Transaction types, command codes, widths and sequencer states.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int HANDLE_W  = 31;
  localparam int INDEX_W   = 4;
  localparam int COUNT_W   = 5;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [INDEX_W-1:0] slot_index;
    logic [COUNT_W-1:0] live_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

[sv/connection_slot_table.sv]
// ----------------------------------------------------------------------------
// Connection slot table
// Adds, removes and finds connection handles in a fixed table of slots.
// ----------------------------------------------------------------------------
// An input transaction on in_* carries a command (add, remove or find) and a
// handle. Each one produces exactly one output transaction on out_* with the
// success flag, the slot index and the number of live slots afterwards.
// Add takes the lowest free slot; remove and find act on the lowest live slot
// holding the handle. The sequencer checks one slot per cycle through the
// handle memory's registered read port until it finds the slot it needs or
// has checked the last slot, and then registers the result for the output
// register. An unused command code skips the scan. in_ready stays low while
// a transaction is in work. The next transaction is accepted in the cycle
// after the previous result enters the output register. The output
// register holds one result, so a new transaction can be accepted while
// the previous result waits; a stalled receiver holds the next result in
// the sequencer until the register frees. Reset empties the table and the
// live count at once; the handle memory is not cleared.
// ----------------------------------------------------------------------------
module connection_slot_table #(
  parameter int SLOTS = cst_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cst_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cst_pkg::out_item_t out_item
);

  `include "connection_slot_table_assert.svh"

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic                         res_valid;
  logic                         res_ready;
  cst_pkg::out_item_t           res_item;
  logic                         mem_rd_en;
  logic [IDX_W-1:0]             mem_rd_addr;
  logic [cst_pkg::HANDLE_W-1:0] mem_rd_data;
  logic                         mem_wr_en;
  logic [IDX_W-1:0]             mem_wr_addr;
  logic [cst_pkg::HANDLE_W-1:0] mem_wr_data;
  logic                         out_valid_r, out_valid_nxt;
  cst_pkg::out_item_t           out_item_r, out_item_nxt;
  logic                         load;

  cst_ctrl #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data)
  );

  cst_handle_mem #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_item_nxt  = res_item;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `CST_ASSERT_SAME(a_index_zero_on_fail, clk, rst_n, out_valid && !out_item.ok,
                   out_item.slot_index == '0)
  `CST_ASSERT_NEXT(a_result_loads_register, clk, rst_n, res_valid && res_ready,
                   out_valid && (out_item == $past(res_item)))

endmodule

[sv/cst_handle_mem.sv]
// ----------------------------------------------------------------------------
// Connection slot table handle memory
// One write port and one registered read port holding the slot handles.
// ----------------------------------------------------------------------------
module cst_handle_mem #(
  parameter int SLOTS = cst_pkg::SLOTS_DEF,
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [cst_pkg::HANDLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic [cst_pkg::HANDLE_W-1:0] rd_data
);

  logic [cst_pkg::HANDLE_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/cst_ctrl.sv]
// ----------------------------------------------------------------------------
// Connection slot table sequencer
// Scans the slots one per cycle with a shared compare and updates the table.
// ----------------------------------------------------------------------------
module cst_ctrl #(
  parameter int SLOTS = cst_pkg::SLOTS_DEF,
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cst_pkg::in_item_t            in_item,
  output logic                         res_valid,
  input  logic                         res_ready,
  output cst_pkg::out_item_t           res_item,
  output logic                         mem_rd_en,
  output logic [IDX_W-1:0]             mem_rd_addr,
  input  logic [cst_pkg::HANDLE_W-1:0] mem_rd_data,
  output logic                         mem_wr_en,
  output logic [IDX_W-1:0]             mem_wr_addr,
  output logic [cst_pkg::HANDLE_W-1:0] mem_wr_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  cst_pkg::state_t              state_r, state_nxt;
  logic [1:0]                   cmd_r, cmd_nxt;
  logic [cst_pkg::HANDLE_W-1:0] handle_r, handle_nxt;
  logic [IDX_W-1:0]             scan_idx_r, scan_idx_nxt;
  logic                         iss_done_r, iss_done_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic                         cmp_last_r, cmp_last_nxt;
  logic [SLOTS-1:0]             valid_r, valid_nxt;
  logic [cst_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                         ok_r, ok_nxt;
  logic [IDX_W-1:0]             found_r, found_nxt;
  logic                         in_fire;
  logic                         cmd_known;
  logic                         hit;
  logic                         miss_end;
  logic [IDX_W+cst_pkg::INDEX_W-1:0] found_ext;

  assign in_fire   = in_valid && in_ready;
  assign cmd_known = (in_item.command == cst_pkg::CMD_ADD) ||
                     (in_item.command == cst_pkg::CMD_REMOVE) ||
                     (in_item.command == cst_pkg::CMD_FIND);
  assign hit = cmp_vld_r && ((cmd_r == cst_pkg::CMD_ADD) ? !valid_r[cmp_idx_r] :
               (valid_r[cmp_idx_r] && (mem_rd_data == handle_r)));
  assign miss_end  = cmp_vld_r && cmp_last_r && !hit;
  assign found_ext = {{cst_pkg::INDEX_W{1'b0}}, found_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cst_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = cmd_known ? cst_pkg::ST_SCAN : cst_pkg::ST_DONE;
        end
      end
      cst_pkg::ST_SCAN: begin
        if (hit || miss_end) begin
          state_nxt = cst_pkg::ST_DONE;
        end
      end
      cst_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = cst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == cst_pkg::ST_IDLE);
    res_valid   = (state_r == cst_pkg::ST_DONE);
    mem_rd_en   = (state_r == cst_pkg::ST_SCAN) && !iss_done_r;
    mem_rd_addr = scan_idx_r;
    mem_wr_en   = (state_r == cst_pkg::ST_SCAN) && hit && (cmd_r == cst_pkg::CMD_ADD);
    mem_wr_addr = cmp_idx_r;
    mem_wr_data = handle_r;
    res_item.ok         = ok_r;
    res_item.slot_index = found_ext[cst_pkg::INDEX_W-1:0];
    res_item.live_count = count_r;
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    handle_nxt   = handle_r;
    scan_idx_nxt = scan_idx_r;
    iss_done_nxt = iss_done_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_last_nxt = cmp_last_r;
    valid_nxt    = valid_r;
    count_nxt    = count_r;
    ok_nxt       = ok_r;
    found_nxt    = found_r;
    case (state_r)
      cst_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt      = in_item.command;
          handle_nxt   = in_item.handle;
          scan_idx_nxt = '0;
          iss_done_nxt = 1'b0;
          cmp_vld_nxt  = 1'b0;
          ok_nxt       = 1'b0;
          found_nxt    = '0;
        end
      end
      cst_pkg::ST_SCAN: begin
        cmp_vld_nxt = !iss_done_r;
        if (!iss_done_r) begin
          cmp_idx_nxt  = scan_idx_r;
          cmp_last_nxt = (scan_idx_r == LAST_IDX);
          if (scan_idx_r == LAST_IDX) begin
            iss_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (hit) begin
          ok_nxt       = 1'b1;
          found_nxt    = cmp_idx_r;
          cmp_vld_nxt  = 1'b0;
          iss_done_nxt = 1'b1;
          if (cmd_r == cst_pkg::CMD_ADD) begin
            valid_nxt[cmp_idx_r] = 1'b1;
            count_nxt            = count_r + 1'b1;
          end else if (cmd_r == cst_pkg::CMD_REMOVE) begin
            valid_nxt[cmp_idx_r] = 1'b0;
            count_nxt            = count_r - 1'b1;
          end
        end else if (miss_end) begin
          cmp_vld_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cst_pkg::ST_IDLE;
      iss_done_r <= 1'b1;
      cmp_vld_r  <= 1'b0;
      valid_r    <= '0;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      iss_done_r <= iss_done_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      valid_r    <= valid_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    handle_r   <= handle_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_last_r <= cmp_last_nxt;
    ok_r       <= ok_nxt;
    found_r    <= found_nxt;
  end

endmodule

[verif/tb_connection_slot_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Connection slot table testbench
// Fills, queries and drains the slot table with add, remove, find and
// unused-code transactions, predicts every answer from a table kept alongside the
// design, and compares each output transaction field by field. Both
// channels idle and stall at random, with stretches of full throughput.
// ----------------------------------------------------------------------------
module tb_connection_slot_table;

  localparam int          NUM_SLOTS   = cst_pkg::SLOTS_DEF;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          STALL_LIMIT = 1000;
  localparam int          SETTLE_CYC  = 40;
  localparam int          RAND_PHASES = 31;
  localparam int          PHASE_ITEMS = 50;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cst_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cst_pkg::out_item_t out_item;

  // Shadow copy of the table that predicts each answer.
  logic                         slot_live [NUM_SLOTS];
  logic [cst_pkg::HANDLE_W-1:0] slot_key [NUM_SLOTS];
  logic [cst_pkg::COUNT_W-1:0]  live_total;

  cst_pkg::out_item_t           expected_slot_results [$];
  logic [cst_pkg::HANDLE_W-1:0] handle_pool [8];
  int                           failures = 0;
  int                           idle_cycles = 0;
  int                           pending_gap = 0;
  bit                           input_held = 1'b0;
  bit                           no_idle = 1'b0;

  connection_slot_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic cst_pkg::out_item_t predict_slot_result(cst_pkg::in_item_t op);
    cst_pkg::out_item_t res;
    int                 hit;
    hit = -1;
    case (op.command)
      cst_pkg::CMD_ADD: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (hit < 0 && !slot_live[i]) hit = i;
        if (hit >= 0) begin
          slot_key[hit]  = op.handle;
          slot_live[hit] = 1'b1;
          live_total     = live_total + 1'b1;
        end
      end
      cst_pkg::CMD_REMOVE, cst_pkg::CMD_FIND: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (hit < 0 && slot_live[i] && slot_key[i] == op.handle) hit = i;
        if (hit >= 0 && op.command == cst_pkg::CMD_REMOVE) begin
          slot_live[hit] = 1'b0;
          live_total     = live_total - 1'b1;
        end
      end
      default: hit = -1;
    endcase
    res.ok         = (hit >= 0);
    res.slot_index = (hit >= 0) ? hit[cst_pkg::INDEX_W-1:0] : '0;
    res.live_count = live_total;
    return res;
  endfunction

  function automatic logic [cst_pkg::HANDLE_W-1:0] random_handle();
    logic [31:0] r;
    r = $urandom;
    return r[cst_pkg::HANDLE_W-1:0];
  endfunction

  function automatic logic [cst_pkg::HANDLE_W-1:0] choose_add_handle();
    if ($urandom_range(0, 9) < 7) return handle_pool[$urandom_range(0, 7)];
    return random_handle();
  endfunction

  function automatic logic [cst_pkg::HANDLE_W-1:0] choose_lookup_handle();
    int live_idx [$];
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_live[i]) live_idx.push_back(i);
    if (live_idx.size() != 0 && $urandom_range(0, 9) < 7)
      return slot_key[live_idx[$urandom_range(0, live_idx.size() - 1)]];
    return choose_add_handle();
  endfunction

  task automatic send_table_op(input logic [1:0] cmd,
                               input logic [cst_pkg::HANDLE_W-1:0] h);
    cst_pkg::in_item_t op;
    repeat (pending_gap) @(posedge clk);
    op.command = cmd;
    op.handle  = h;
    in_item  <= op;
    in_valid <= 1'b1;
    expected_slot_results.push_back(predict_slot_result(op));
    do @(posedge clk); while (!in_ready);
    pending_gap = no_idle ? 0 : $urandom_range(0, 10);
    input_held  = (pending_gap == 0);
    if (!input_held) in_valid <= 1'b0;
  endtask

  task automatic release_input();
    if (input_held) begin
      in_valid  <= 1'b0;
      input_held = 1'b0;
    end
  endtask

  task automatic drain_results();
    release_input();
    while (expected_slot_results.size() != 0) @(posedge clk);
  endtask

  // Sixteen adds with extreme and repeated handles fill the table, then one
  // more add must be refused.
  task automatic test_fill_and_overflow();
    send_table_op(cst_pkg::CMD_ADD, 31'h0000_0000);
    send_table_op(cst_pkg::CMD_ADD, 31'h7FFF_FFFF);
    send_table_op(cst_pkg::CMD_ADD, 31'h5555_5555);
    send_table_op(cst_pkg::CMD_ADD, 31'h2AAA_AAAA);
    send_table_op(cst_pkg::CMD_ADD, 31'h1234_5678);
    send_table_op(cst_pkg::CMD_ADD, 31'h1234_5678);
    for (int k = 0; k < 10; k++)
      send_table_op(cst_pkg::CMD_ADD, 31'h1 << (k * 3));
    send_table_op(cst_pkg::CMD_ADD, 31'h0ABC_DEF0);
  endtask

  // Lookups and removals on the full table, including a duplicate handle,
  // misses, the unused command code and reuse of a freed slot.
  task automatic test_lookup_and_remove();
    send_table_op(cst_pkg::CMD_FIND,   31'h7FFF_FFFF);
    send_table_op(cst_pkg::CMD_FIND,   31'h1234_5678);
    send_table_op(cst_pkg::CMD_REMOVE, 31'h1234_5678);
    send_table_op(cst_pkg::CMD_FIND,   31'h1234_5678);
    send_table_op(cst_pkg::CMD_FIND,   31'h0ABC_DEF0);
    send_table_op(cst_pkg::CMD_REMOVE, 31'h0ABC_DEF0);
    send_table_op(CMD_UNUSED,          31'h7FFF_FFFF);
    send_table_op(cst_pkg::CMD_ADD,    31'h0ABC_DEF0);
    drain_results();
  endtask

  // Phases that lean toward filling, draining or a balanced mix, so the
  // table swings between empty and full.
  task automatic test_random_traffic();
    int mode;
    int add_pct;
    int rem_pct;
    int r;
    for (int i = 0; i < 8; i++) handle_pool[i] = random_handle();
    for (int p = 0; p < RAND_PHASES; p++) begin
      mode    = $urandom_range(0, 2);
      add_pct = (mode == 0) ? 60 : (mode == 1) ? 20 : 40;
      rem_pct = (mode == 0) ? 20 : (mode == 1) ? 55 : 35;
      no_idle = (p % 5 == 2);
      handle_pool[$urandom_range(0, 7)] = random_handle();
      handle_pool[$urandom_range(0, 7)] = random_handle();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < add_pct)
          send_table_op(cst_pkg::CMD_ADD, choose_add_handle());
        else if (r < add_pct + rem_pct)
          send_table_op(cst_pkg::CMD_REMOVE, choose_lookup_handle());
        else if (r < 96)
          send_table_op(cst_pkg::CMD_FIND, choose_lookup_handle());
        else
          send_table_op(CMD_UNUSED, random_handle());
      end
      if (p % 8 == 7) drain_results();
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_key[i]  = '0;
    end
    live_total = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_and_overflow();
    test_lookup_and_remove();
    test_random_traffic();
    repeat (SETTLE_CYC) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    cst_pkg::out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_slot_results.size() == 0) begin
        $error("Output transaction with no expected result: ok %0d slot %0d live %0d",
               out_item.ok, out_item.slot_index, out_item.live_count);
        failures++;
      end else begin
        exp_res = expected_slot_results.pop_front();
        if (out_item.ok !== exp_res.ok) begin
          $error("ok mismatch: expected %0d, actual %0d", exp_res.ok, out_item.ok);
          failures++;
        end
        if (out_item.slot_index !== exp_res.slot_index) begin
          $error("slot_index mismatch: expected %0d, actual %0d",
                 exp_res.slot_index, out_item.slot_index);
          failures++;
        end
        if (out_item.live_count !== exp_res.live_count) begin
          $error("live_count mismatch: expected %0d, actual %0d",
                 exp_res.live_count, out_item.live_count);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
